@@ sv/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Opcodes with special handling
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // Short length codes in the second header byte
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Extended length and mask key byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  // Number of payload bytes a close frame may deliver
  localparam logic [31:0] CLOSE_BYTES = 32'd2;

  // Reset value of the data payload limit
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1023;

  // Saturation value of the delivered count
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Frame status codes
  localparam logic [1:0] ST_DATA_OK   = 2'd0;
  localparam logic [1:0] ST_PING_ECHO = 2'd1;
  localparam logic [1:0] ST_CLOSE     = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  // Input transaction
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [3:0]  frame_opcode;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] copied_count;
  } out_item_t;

endpackage

@@ sv/wsd_in_reg.sv @@
// ----------------------------------------------------------------------------
// wsd_in_reg
// Input register stage: captures one byte transaction per cycle while in_ready is high.
// ----------------------------------------------------------------------------
module wsd_in_reg
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     s_valid,
  input  logic     s_take,
  output in_item_t s_data
);

  logic     valid_r;
  in_item_t data_r;

  // Refill whenever empty or the held item moves on this cycle
  assign in_ready = !valid_r || s_take;
  assign s_valid  = valid_r;
  assign s_data   = data_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

endmodule

@@ sv/wsd_parser.sv @@
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasking; holds per-frame state and the
// payload limit register. State advances on each consumed byte.
// ----------------------------------------------------------------------------
module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        step,
  input  in_item_t    item,
  output out_item_t   result
);

  phase_t      phase_r,   phase_nxt;
  logic [3:0]  hidx_r,    hidx_nxt;
  logic [3:0]  opcode_r,  opcode_nxt;
  logic        mask_r,    mask_nxt;
  logic [31:0] len_r,     len_nxt;
  logic [31:0] key_r,     key_nxt;
  logic [31:0] pos_r,     pos_nxt;
  logic [15:0] dcnt_r,    dcnt_nxt;
  logic [15:0] max_pay_r;

  phase_t      phase_adv;
  logic        in_payload;
  logic        take;
  logic [7:0]  pb;
  logic [7:0]  key_byte;
  logic [3:0]  hidx_inc;
  logic [3:0]  ext_need;
  logic [1:0]  status;

  // Payload limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pay_r <= MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      max_pay_r <= cfg_wr_data;
    end
  end

  // Mask key byte for this payload position
  always_comb begin
    case (pos_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Payload byte selection
  assign in_payload = (phase_r == PH_PAYLOAD) && (pos_r < len_r);

  always_comb begin
    take = 1'b0;
    pb   = 8'h00;
    if (in_payload) begin
      if (opcode_r == OP_PING) begin
        take = 1'b1;
        pb   = item.rx_byte;
      end else if (opcode_r == OP_CLOSE) begin
        if (pos_r < CLOSE_BYTES) begin
          take = 1'b1;
          pb   = item.rx_byte;
        end
      end else if (dcnt_r < max_pay_r) begin
        take = 1'b1;
        pb   = mask_r ? (item.rx_byte ^ key_byte) : item.rx_byte;
      end
    end
  end

  assign hidx_inc = hidx_r + 4'd1;
  assign ext_need = (phase_r == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;

  // Next state
  always_comb begin
    phase_adv  = phase_r;
    hidx_nxt   = hidx_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    dcnt_nxt   = dcnt_r;
    case (phase_r)
      PH_HDR0: begin
        opcode_nxt = item.rx_byte[3:0];
        mask_nxt   = 1'b0;
        len_nxt    = '0;
        key_nxt    = '0;
        pos_nxt    = '0;
        dcnt_nxt   = '0;
        hidx_nxt   = '0;
        phase_adv  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_nxt = item.rx_byte[7];
        hidx_nxt = '0;
        len_nxt  = '0;
        if (item.rx_byte[6:0] == LEN_CODE_EXT16) begin
          phase_adv = PH_EXT16;
        end else if (item.rx_byte[6:0] == LEN_CODE_EXT64) begin
          phase_adv = PH_EXT64;
        end else begin
          len_nxt   = {25'd0, item.rx_byte[6:0]};
          phase_adv = item.rx_byte[7] ? PH_MASK : PH_PAYLOAD;
        end
      end
      PH_EXT16, PH_EXT64: begin
        // Only the low 32 bits of a 64-bit length survive the shift
        len_nxt  = {len_r[23:0], item.rx_byte};
        hidx_nxt = hidx_inc;
        if (hidx_inc >= ext_need) begin
          hidx_nxt  = '0;
          phase_adv = mask_r ? PH_MASK : PH_PAYLOAD;
        end
      end
      PH_MASK: begin
        key_nxt  = {key_r[23:0], item.rx_byte};
        hidx_nxt = hidx_inc;
        if (hidx_inc >= MASK_BYTES) begin
          hidx_nxt  = '0;
          phase_adv = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (in_payload) begin
          pos_nxt = pos_r + 32'd1;
          if (take && (dcnt_r != COUNT_MAX)) begin
            dcnt_nxt = dcnt_r + 16'd1;
          end
        end
      end
      default: begin
        phase_adv = PH_HDR0;
        hidx_nxt  = '0;
      end
    endcase
    // Last byte closes the frame
    phase_nxt = phase_adv;
    if (item.last_byte) begin
      phase_nxt = PH_HDR0;
      hidx_nxt  = '0;
    end
  end

  // Frame status on the last byte
  always_comb begin
    status = ST_DATA_OK;
    if (item.last_byte) begin
      if (phase_adv != PH_PAYLOAD) begin
        status = ST_TRUNC;
      end else if (opcode_nxt == OP_PING) begin
        status = ST_PING_ECHO;
      end else if (opcode_nxt == OP_CLOSE) begin
        status = ST_CLOSE;
      end else begin
        status = ST_DATA_OK;
      end
    end
  end

  // Result assembly
  assign result.payload_byte  = pb;
  assign result.payload_valid = take;
  assign result.frame_opcode  = opcode_nxt;
  assign result.frame_end     = item.last_byte;
  assign result.status        = status;
  assign result.copied_count  = dcnt_nxt;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      hidx_r   <= '0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      key_r    <= '0;
      pos_r    <= '0;
      dcnt_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

endmodule

@@ sv/wsd_out_reg.sv @@
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register stage: holds one result transaction until taken.
// ----------------------------------------------------------------------------
module wsd_out_reg
  import wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      r_valid,
  output logic      r_ready,
  input  out_item_t r_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t data_r;

  // Accept a new result when empty or the held one leaves this cycle
  assign r_ready   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (r_ready) begin
      valid_r <= r_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (r_ready && r_valid) begin
      data_r <= r_data;
    end
  end

endmodule

@@ sv/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: one byte in, one result out.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  input   | in_valid / in_ready / in_data      | in
//  result  | out_valid / out_ready / out_data   | out
//  config  | cfg_wr_en / cfg_wr_data            | in
//
//  One byte accepted per cycle while in_ready is high, one result per byte;
//  bytes pass the input register, then parser logic into the result register.
//  The parser updates its state once per accepted byte.
//  rst_n is synchronous, active low; max_payload resets to 1023.
//  A stalled result holds in the result register and backpressure reaches
//  in_ready in the same cycle.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic      s_valid;
  logic      s_take;
  in_item_t  s_data;
  out_item_t p_result;
  logic      r_ready;

  // Byte moves from the input register into the result register
  assign s_take = s_valid && r_ready;

  wsd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_take   (s_take),
    .s_data   (s_data)
  );

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (s_take),
    .item        (s_data),
    .result      (p_result)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .r_valid   (s_valid),
    .r_ready   (r_ready),
    .r_data    (p_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/wsd_checker.sv @@
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks for the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module wsd_checker
  import wsd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Undelivered byte reads as zero
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'h00)
    else $error("payload byte nonzero without payload_valid");

  // Status only on the frame's last transaction
  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_end |-> out_data.status == ST_DATA_OK)
    else $error("status set before frame end");

  // Truncated header never delivers payload
  a_trunc_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_TRUNC |-> out_data.copied_count == 16'd0)
    else $error("truncated header with nonzero count");

  // A delivered byte is counted
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.payload_valid |-> out_data.copied_count != 16'd0)
    else $error("delivered byte with zero count");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
